// File: src/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
package lpd_pkg;

   localparam int unsigned HDR_BYTES = 4;
   localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd8196;
   localparam logic [15:0] MIN_FRAME_LEN = 16'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       session_restart;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_body;
      logic       last_of_frame;
      logic       frame_error;
   } rsp_item_type;

endpackage

// File: src/lpd_in_reg.sv
// Input register stage: captures one request transfer and holds it until it is processed.
module lpd_in_reg
   import lpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   input  logic         take,
   output logic         hold_valid,
   output req_item_type hold_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// File: src/lpd_frame_ctl.sv
// Framing state, maximum length register and the per-byte header/body decision.
module lpd_frame_ctl
   import lpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [1:0]  hdr_cnt_ff,  hdr_cnt_in;
   logic [23:0] len_acc_ff,  len_acc_in;   // top header byte is never stored
   logic [15:0] body_rem_ff, body_rem_in;
   logic        closed_ff,   closed_in;
   logic [15:0] max_len_ff;

   logic [1:0]  cur_cnt;
   logic [23:0] cur_acc;
   logic [15:0] cur_rem;
   logic        cur_closed;
   logic [31:0] full_len;
   logic        bad_len;
   logic        body_bit, last_bit, err_bit;

   // restart wipes the state before this byte is looked at
   assign cur_cnt    = item.session_restart ? 2'd0  : hdr_cnt_ff;
   assign cur_acc    = item.session_restart ? 24'd0 : len_acc_ff;
   assign cur_rem    = item.session_restart ? 16'd0 : body_rem_ff;
   assign cur_closed = item.session_restart ? 1'b0  : closed_ff;

   assign full_len = {item.data_byte, cur_acc};
   // negative or above 16 bits is always over the maximum
   assign bad_len  = (full_len[31:16] != 16'd0) || (full_len[15:0] > max_len_ff) ||
                     (full_len[15:0] < MIN_FRAME_LEN);

   always_comb begin
      hdr_cnt_in  = cur_cnt;
      len_acc_in  = cur_acc;
      body_rem_in = cur_rem;
      closed_in   = cur_closed;
      body_bit    = 1'b0;
      last_bit    = 1'b0;
      err_bit     = 1'b0;
      if (cur_closed) begin
         err_bit = 1'b1;
      end else if (cur_rem != 16'd0) begin
         body_bit    = 1'b1;
         body_rem_in = cur_rem - 16'd1;
         last_bit    = (cur_rem == 16'd1);
      end else begin
         case (cur_cnt)
            2'd0: begin
               len_acc_in[7:0] = item.data_byte;
               hdr_cnt_in      = 2'd1;
            end
            2'd1: begin
               len_acc_in[15:8] = item.data_byte;
               hdr_cnt_in       = 2'd2;
            end
            2'd2: begin
               len_acc_in[23:16] = item.data_byte;
               hdr_cnt_in        = 2'd3;
            end
            default: begin
               hdr_cnt_in = 2'd0;
               len_acc_in = 24'd0;
               if (bad_len) begin
                  closed_in = 1'b1;
                  err_bit   = 1'b1;
               end else begin
                  body_rem_in = full_len[15:0] - MIN_FRAME_LEN;
                  last_bit    = (full_len[15:0] == MIN_FRAME_LEN);
               end
            end
         endcase
      end
   end

   assign result.out_byte      = item.data_byte;
   assign result.in_body       = body_bit;
   assign result.last_of_frame = last_bit;
   assign result.frame_error   = err_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= 2'd0;
         len_acc_ff  <= 24'd0;
         body_rem_ff <= 16'd0;
         closed_ff   <= 1'b0;
      end else if (step) begin
         hdr_cnt_ff  <= hdr_cnt_in;
         len_acc_ff  <= len_acc_in;
         body_rem_ff <= body_rem_in;
         closed_ff   <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_LEN_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

endmodule

// File: src/lpd_out_reg.sv
// Result register: holds one tagged byte until the response transfer completes.
module lpd_out_reg
   import lpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: src/length_prefix_deframer_top.sv
// Top level of the length-prefix deframer.
//
//   channel   ports                         direction  meaning
//   req       req_valid/req_ready + fields  in         one stream byte, restart flag
//   rsp       rsp_valid/rsp_ready + fields  out        byte tagged header/body/last/error
//   csr       csr_we, csr_wdata[15:0]       in         max_frame_len write, no wait
//
// One byte per cycle sustained while rsp_ready is high; a byte is offered on rsp after it passes
// through the input register, then the header/body logic into the result register.
// The framing state updates in the same cycle the byte leaves the input register.
// Synchronous reset clears framing state and sets max_frame_len to 8196.
// A stall on rsp holds both registers; req_ready drops only when both are full.
module length_prefix_deframer_top
   import lpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_session_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_in_body,
   output logic        rsp_last_of_frame,
   output logic        rsp_frame_error,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   req_item_type req_item;
   req_item_type hold_item;
   rsp_item_type step_result;
   rsp_item_type rsp_item;
   logic         hold_valid;
   logic         step;

   assign req_item.data_byte       = req_data_byte;
   assign req_item.session_restart = req_session_restart;

   // advance when the result register is empty or being emptied
   assign step = hold_valid && (!rsp_valid || rsp_ready);

   lpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (step),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   lpd_frame_ctl u_frame_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (hold_item),
      .result    (step_result)
   );

   lpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (step_result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_byte      = rsp_item.out_byte;
   assign rsp_in_body       = rsp_item.in_body;
   assign rsp_last_of_frame = rsp_item.last_of_frame;
   assign rsp_frame_error   = rsp_item.frame_error;

endmodule

// File: src/lpd_checker.sv
// Port-level checker for the length-prefix deframer, bound to the top level.
module lpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_in_body,
   input logic        rsp_last_of_frame,
   input logic        rsp_frame_error
);

   // a result stays offered until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_in_body) &&
         $stable(rsp_last_of_frame) && $stable(rsp_frame_error))
      else $error("rsp payload changed while stalled");

   // a discarded byte is never tagged as body
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_in_body && rsp_frame_error))
      else $error("error byte tagged as body");

   // a discarded byte never closes a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_last_of_frame && rsp_frame_error))
      else $error("error byte marked last of frame");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind length_prefix_deframer_top lpd_checker u_lpd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_in_body       (rsp_in_body),
   .rsp_last_of_frame (rsp_last_of_frame),
   .rsp_frame_error   (rsp_frame_error)
);
